// ----- rtl/sps_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sps_pkg
// Shared codes, constants and types of the strand pair scoring core.
// ----------------------------------------------------------------------------
package sps_pkg;

    // item opcodes
    localparam logic [1:0] OP_WRITE_TABLE = 2'd0;
    localparam logic [1:0] OP_LOAD_PAIR   = 2'd1;
    localparam logic [1:0] OP_COMPUTE     = 2'd2;

    // score table selects
    localparam logic [1:0] TBL_STRONG = 2'd0;
    localparam logic [1:0] TBL_VDW    = 2'd1;
    localparam logic [1:0] TBL_WEAK   = 2'd2;

    // residue coding
    localparam int         RES_BITS  = 5;
    localparam logic [4:0] RES_LIMIT = 5'd19;
    localparam logic [4:0] RES_GLY   = 5'd7;
    localparam logic [9:0] RES_COUNT = 10'd20;

    // score tables
    localparam int         PAIR_BITS = 8;
    localparam logic [7:0] NUM_PAIRS = 8'd210;
    localparam int         TABLE_DEPTH = 210;

    // result width
    localparam int SUM_BITS = 24;

    // triangular table index of a residue pair
    typedef struct packed {
        logic                 valid;
        logic [PAIR_BITS-1:0] idx;
    } tri_t;

    // controller to datapath commands
    typedef struct packed {
        logic tbl_wr;
        logic strand_wr;
        logic start;
        logic issue;
        logic first;
        logic odd;
        logic push;
    } cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic busy;
        logic out_free;
    } status_t;

    // symmetric triangular index: lo*20 + hi - lo*(lo+1)/2
    function automatic tri_t tri_index(input logic [RES_BITS-1:0] a,
                                       input logic [RES_BITS-1:0] b);
        logic [RES_BITS-1:0] lo;
        logic [RES_BITS-1:0] hi;
        logic [9:0]          base;
        logic [9:0]          sub;
        tri_t                r;
        lo      = (a < b) ? a : b;
        hi      = (a < b) ? b : a;
        base    = 10'(lo) * RES_COUNT + 10'(hi);
        sub     = (10'(lo) * (10'(lo) + 10'd1)) >> 1;
        r.valid = (a <= RES_LIMIT) && (b <= RES_LIMIT);
        r.idx   = PAIR_BITS'(base - sub);
        return r;
    endfunction

endpackage

// ----- rtl/sps_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sps_ctrl
// Controller: decodes items, walks the strand positions of a compute and
// hands the finished sum to the output register.
// ----------------------------------------------------------------------------
module sps_ctrl #(
    parameter int MAX_STRAND = 32
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [1:0]                            s_opcode,
    input  logic [5:0]                            s_strand_length,
    input  sps_pkg::status_t                      status,
    output sps_pkg::cmd_t                         cmd,
    output logic [$clog2(MAX_STRAND)-1:0]         rd_pos
);
    import sps_pkg::*;

    localparam int AW = $clog2(MAX_STRAND);
    localparam int CW = $clog2(MAX_STRAND + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN
    } state_t;

    state_t        state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] len_reg, len_next;
    logic [CW-1:0] len_sat;
    logic [CW-1:0] cnt_inc;
    logic          accept;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;
    assign cnt_inc = cnt_reg + CW'(1);
    assign rd_pos  = cnt_reg[AW-1:0];

    // length clipped to the strand storage
    assign len_sat = (9'(s_strand_length) > 9'(MAX_STRAND)) ? CW'(MAX_STRAND)
                                                            : CW'(s_strand_length);

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        len_next   = len_reg;
        cmd        = '0;
        cmd.first  = (cnt_reg == '0);
        cmd.odd    = cnt_reg[0];
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    unique case (s_opcode)
                        OP_WRITE_TABLE: cmd.tbl_wr = 1'b1;
                        OP_LOAD_PAIR:   cmd.strand_wr = 1'b1;
                        OP_COMPUTE: begin
                            cmd.start  = 1'b1;
                            cnt_next   = '0;
                            len_next   = len_sat;
                            state_next = (s_strand_length == 6'd0) ? ST_DRAIN : ST_ISSUE;
                        end
                        default: ;
                    endcase
                end
            end
            ST_ISSUE: begin
                cmd.issue = 1'b1;
                cnt_next  = cnt_inc;
                if (cnt_inc == len_reg) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!status.busy && status.out_free) begin
                    cmd.push   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // state and counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            len_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            len_reg   <= len_next;
        end
    end

endmodule

// ----- rtl/sps_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sps_datapath
// Datapath: strand and score memories, a three stage scoring pipeline
// (strand read, table read, accumulate) and the output register.
// ----------------------------------------------------------------------------
module sps_datapath #(
    parameter int MAX_STRAND = 32,
    parameter int SCORE_BITS = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  sps_pkg::cmd_t                     cmd,
    input  logic [$clog2(MAX_STRAND)-1:0]     rd_pos,
    output sps_pkg::status_t                  status,
    input  logic [1:0]                        s_table_select,
    input  logic [7:0]                        s_pair_index,
    input  logic signed [15:0]                s_table_score,
    input  logic [4:0]                        s_position,
    input  logic [4:0]                        s_residue_first,
    input  logic [4:0]                        s_residue_second,
    input  logic                              s_bond_pattern,
    input  logic                              s_orientation,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [23:0]                m_pair_score
);
    import sps_pkg::*;

    localparam int AW        = $clog2(MAX_STRAND);
    localparam int ACC_RAW   = SCORE_BITS + $clog2(MAX_STRAND) + 2;
    localparam int ACC_BITS  = (ACC_RAW > SUM_BITS) ? ACC_RAW : SUM_BITS;
    localparam logic signed [32:0] SCORE_MAX = (33'sd1 <<< (SCORE_BITS - 1)) - 33'sd1;
    localparam logic signed [32:0] SCORE_MIN = -SCORE_MAX - 33'sd1;
    localparam logic signed [ACC_BITS-1:0] SUM_MAX = ACC_BITS'(24'sh7FFFFF);
    localparam logic signed [ACC_BITS-1:0] SUM_MIN = ACC_BITS'(24'sh800000);

    // memories
    logic [RES_BITS-1:0]          first_mem  [MAX_STRAND];
    logic [RES_BITS-1:0]          second_mem [MAX_STRAND];
    logic signed [SCORE_BITS-1:0] strong_mem [TABLE_DEPTH];
    logic signed [SCORE_BITS-1:0] vdw_mem    [TABLE_DEPTH];
    logic signed [SCORE_BITS-1:0] weak_mem   [TABLE_DEPTH];

    // write side
    logic                         pos_ok;
    logic                         idx_ok;
    logic signed [32:0]           score_wide;
    logic signed [SCORE_BITS-1:0] score_sat;
    logic [AW-1:0]                wr_pos;

    // pipeline
    logic                         pattern_reg, orient_reg;
    logic                         p1_valid_reg, p1_first_reg, p1_odd_reg;
    logic [RES_BITS-1:0]          a_rd_reg, b_rd_reg;
    logic [RES_BITS-1:0]          ap_reg, bp_reg;
    tri_t                         pat_tri, weak_tri;
    logic [PAIR_BITS-1:0]         pat_addr, weak_addr;
    logic                         strong_here;
    logic                         use_strong, use_vdw, use_weak;
    logic                         p2_valid_reg;
    logic                         p2_strong_reg, p2_vdw_reg, p2_weak_reg;
    logic signed [SCORE_BITS-1:0] strong_q_reg, vdw_q_reg, weak_q_reg;
    logic signed [ACC_BITS-1:0]   pat_term, weak_term;
    logic signed [ACC_BITS-1:0]   acc_reg, acc_next;
    logic signed [23:0]           sum_sat;
    logic                         m_valid_reg;
    logic signed [23:0]           m_score_reg;

    // write qualification and score clipping
    assign pos_ok     = 9'(s_position) < 9'(MAX_STRAND);
    assign idx_ok     = s_pair_index < NUM_PAIRS;
    assign wr_pos     = AW'(s_position);
    assign score_wide = 33'(s_table_score);
    assign score_sat  = (score_wide > SCORE_MAX) ? SCORE_BITS'(SCORE_MAX) :
                        (score_wide < SCORE_MIN) ? SCORE_BITS'(SCORE_MIN) :
                                                   SCORE_BITS'(score_wide);

    // strand memories, read at the issued position
    always_ff @(posedge aclk) begin
        if (cmd.strand_wr && pos_ok) begin
            first_mem[wr_pos]  <= s_residue_first;
            second_mem[wr_pos] <= s_residue_second;
        end
        a_rd_reg <= first_mem[rd_pos];
        b_rd_reg <= second_mem[rd_pos];
    end

    // stage one: pair indices of this position and of the diagonal neighbour
    assign pat_tri     = tri_index(a_rd_reg, b_rd_reg);
    assign weak_tri    = orient_reg ? tri_index(ap_reg, b_rd_reg)
                                    : tri_index(bp_reg, a_rd_reg);
    assign pat_addr    = pat_tri.valid ? pat_tri.idx : '0;
    assign weak_addr   = weak_tri.valid ? weak_tri.idx : '0;
    assign strong_here = ~(p1_odd_reg ^ pattern_reg);
    assign use_strong  = p1_valid_reg && pat_tri.valid && strong_here;
    assign use_vdw     = p1_valid_reg && pat_tri.valid && !strong_here &&
                         !((a_rd_reg == RES_GLY) && (b_rd_reg == RES_GLY));
    assign use_weak    = p1_valid_reg && !p1_first_reg && weak_tri.valid;

    // score tables
    always_ff @(posedge aclk) begin
        if (cmd.tbl_wr && idx_ok && (s_table_select == TBL_STRONG)) begin
            strong_mem[s_pair_index] <= score_sat;
        end
        strong_q_reg <= strong_mem[pat_addr];
    end

    always_ff @(posedge aclk) begin
        if (cmd.tbl_wr && idx_ok && (s_table_select == TBL_VDW)) begin
            vdw_mem[s_pair_index] <= score_sat;
        end
        vdw_q_reg <= vdw_mem[pat_addr];
    end

    always_ff @(posedge aclk) begin
        if (cmd.tbl_wr && idx_ok && (s_table_select == TBL_WEAK)) begin
            weak_mem[s_pair_index] <= score_sat;
        end
        weak_q_reg <= weak_mem[weak_addr];
    end

    // stage two: accumulate
    assign pat_term  = p2_strong_reg ? ACC_BITS'(strong_q_reg) :
                       p2_vdw_reg    ? ACC_BITS'(vdw_q_reg)    : '0;
    assign weak_term = p2_weak_reg ? ACC_BITS'(weak_q_reg) : '0;
    assign acc_next  = acc_reg + pat_term + weak_term;

    // clip the sum to the result range
    assign sum_sat = (acc_reg > SUM_MAX) ? 24'sh7FFFFF :
                     (acc_reg < SUM_MIN) ? 24'sh800000 : 24'(acc_reg);

    // pipeline payload
    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            pattern_reg <= s_bond_pattern;
            orient_reg  <= s_orientation;
        end
        p1_first_reg  <= cmd.first;
        p1_odd_reg    <= cmd.odd;
        if (p1_valid_reg) begin
            ap_reg <= a_rd_reg;
            bp_reg <= b_rd_reg;
        end
        p2_strong_reg <= use_strong;
        p2_vdw_reg    <= use_vdw;
        p2_weak_reg   <= use_weak;
        if (cmd.start) begin
            acc_reg <= '0;
        end else if (p2_valid_reg) begin
            acc_reg <= acc_next;
        end
        if (cmd.push) begin
            m_score_reg <= sum_sat;
        end
    end

    // pipeline and output control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            p1_valid_reg <= cmd.issue;
            p2_valid_reg <= p1_valid_reg;
            if (cmd.push) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign status.busy     = p1_valid_reg || p2_valid_reg;
    assign status.out_free = !m_valid_reg || m_ready;
    assign m_valid         = m_valid_reg;
    assign m_pair_score    = m_score_reg;

endmodule

// ----- rtl/strand_pair_score_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// strand_pair_score_core
// Pairing score of two aligned residue strands from three weighted tables.
// ----------------------------------------------------------------------------
// Usage: items enter on the s_ channel (valid/ready). An opcode selects a
// table write, a residue pair load at one strand position, or a compute.
// Table writes and loads return nothing. A compute returns one m_pair_score
// item on the m_ channel (valid/ready). A compute of length L (clipped to
// MAX_STRAND) reads one position per cycle through the single read port of
// the strand memories; each position then passes table read and accumulate,
// and the sum is loaded into the output register. A compute of length zero
// returns zero. s_ready stays low from a compute until its sum is loaded into
// the output register, so no new item is taken while a compute runs.
// Stall: the result sits in an output register; while it waits, loads and
// table writes are still taken. A following compute finishes its sum and
// then holds until the output register is free.
// Reset: aresetn (synchronous, active low) clears control state only; the
// strand and table memories hold no value until written.
// ----------------------------------------------------------------------------
module strand_pair_score_core #(
    parameter int MAX_STRAND = 32,
    parameter int SCORE_BITS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_opcode,
    input  logic [1:0]         s_table_select,
    input  logic [7:0]         s_pair_index,
    input  logic signed [15:0] s_table_score,
    input  logic [4:0]         s_position,
    input  logic [4:0]         s_residue_first,
    input  logic [4:0]         s_residue_second,
    input  logic [5:0]         s_strand_length,
    input  logic               s_bond_pattern,
    input  logic               s_orientation,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [23:0] m_pair_score
);
    import sps_pkg::*;

    cmd_t                          cmd;
    status_t                       status;
    logic [$clog2(MAX_STRAND)-1:0] rd_pos;

    // controller
    sps_ctrl #(
        .MAX_STRAND (MAX_STRAND)
    ) u_ctrl (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_opcode        (s_opcode),
        .s_strand_length (s_strand_length),
        .status          (status),
        .cmd             (cmd),
        .rd_pos          (rd_pos)
    );

    // datapath
    sps_datapath #(
        .MAX_STRAND (MAX_STRAND),
        .SCORE_BITS (SCORE_BITS)
    ) u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .rd_pos           (rd_pos),
        .status           (status),
        .s_table_select   (s_table_select),
        .s_pair_index     (s_pair_index),
        .s_table_score    (s_table_score),
        .s_position       (s_position),
        .s_residue_first  (s_residue_first),
        .s_residue_second (s_residue_second),
        .s_bond_pattern   (s_bond_pattern),
        .s_orientation    (s_orientation),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_pair_score     (m_pair_score)
    );

endmodule
